// File: hdl/icdt_pkg.sv
// shared types, constants and codes for the dual timer interrupt controller
package icdt_pkg;

   localparam int TIMER_COUNT_DEF = 2;
   localparam int TIMER_IDX_W     = 3;
   localparam int PERIOD_W        = 21;
   localparam int CYCLES_W        = 16;

   localparam logic [PERIOD_W-1:0] RATE_STEP   = 21'd4263;
   localparam logic [2:0]          EXT_IRQ_BIT = 3'd3;
   localparam logic [7:0]          PENDING_NONE = 8'hff;
   localparam logic [7:0]          ENABLE_NONE  = 8'hff;

   typedef enum logic [2:0] {
      MODE_TICK,
      MODE_TIMER_WR,
      MODE_IRQ_EN_WR,
      MODE_FIQ_EN_WR,
      MODE_PEND_RD,
      MODE_EXT_IRQ,
      MODE_EXT_FIQ,
      MODE_RAISE
   } mode_type;

   typedef struct packed {
      mode_type            mode;
      logic [CYCLES_W-1:0] cycles;
      logic                timer_select;
      logic [7:0]          write_data;
      logic                level;
      logic [2:0]          irq_bit;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_line;
      logic       fiq_pulse;
   } rsp_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_ADD,
      SEQ_SUB,
      SEQ_DONE
   } seq_state_type;

   typedef enum logic [1:0] {
      TMR_NOP,
      TMR_ADD,
      TMR_SUB,
      TMR_LOAD
   } tmr_op_type;

   typedef struct packed {
      tmr_op_type              op;
      logic [TIMER_IDX_W-1:0]  index;
      logic [CYCLES_W-1:0]     cycles;
      logic [PERIOD_W-1:0]     period;
   } tmr_ctl_type;

   typedef struct packed {
      logic zero;
      logic ge;
   } tmr_sts_type;

endpackage

// File: hdl/icdt_timers.sv
// timer period and count storage with the one shared add/subtract unit
module icdt_timers #(
   parameter int TIMER_COUNT = icdt_pkg::TIMER_COUNT_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  icdt_pkg::tmr_ctl_type tmr_ctl,
   output icdt_pkg::tmr_sts_type tmr_sts
);
   import icdt_pkg::*;

   localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

   logic [PERIOD_W-1:0] period_ff [TIMER_COUNT];
   logic [PERIOD_W-1:0] period_in [TIMER_COUNT];
   logic [PERIOD_W-1:0] count_ff  [TIMER_COUNT];
   logic [PERIOD_W-1:0] count_in  [TIMER_COUNT];

   logic [IDX_W-1:0]    idx;
   logic [PERIOD_W-1:0] cur_period;
   logic [PERIOD_W-1:0] cur_count;
   logic [PERIOD_W-1:0] operand_b;
   logic                carry_in;
   logic [PERIOD_W:0]   sum;

   assign idx        = tmr_ctl.index[IDX_W-1:0];
   assign cur_period = period_ff[idx];
   assign cur_count  = count_ff[idx];

   // add cycles, or subtract the period as count + ~period + 1
   assign operand_b = (tmr_ctl.op == TMR_ADD) ? PERIOD_W'(tmr_ctl.cycles) : ~cur_period;
   assign carry_in  = (tmr_ctl.op != TMR_ADD);
   assign sum       = {1'b0, cur_count} + {1'b0, operand_b} + (PERIOD_W + 1)'(carry_in);

   // carry out of the subtraction means no borrow
   assign tmr_sts.zero = (cur_period == '0);
   assign tmr_sts.ge   = sum[PERIOD_W];

   always_comb begin
      period_in = period_ff;
      count_in  = count_ff;
      unique case (tmr_ctl.op)
         TMR_LOAD: begin
            period_in[idx] = tmr_ctl.period;
            count_in[idx]  = '0;
         end
         TMR_ADD: begin
            count_in[idx] = sum[PERIOD_W-1:0];
         end
         TMR_SUB: begin
            if (sum[PERIOD_W]) begin
               count_in[idx] = sum[PERIOD_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TIMER_COUNT; i++) begin
            period_ff[i] <= '0;
            count_ff[i]  <= '0;
         end
      end else begin
         period_ff <= period_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/interrupt_controller_dual_timer.sv
// top level: request sequencer, pending and enable registers, response register
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid, req_stall | req_payload (icdt_pkg::req_type)
//   rsp_    | out       | rsp_valid, rsp_stall | rsp_payload (icdt_pkg::rsp_type)
//
// a non-tick request is accepted in SEQ_IDLE, then loads the response in
// SEQ_DONE. a tick does the same, but between them, per timer, SEQ_ADD skips a
// stopped timer or adds the cycles, then SEQ_SUB takes off the k elapsed periods
// (at most 8) one by one; the single shared adder does one add or subtract per cycle.
// reset is synchronous; req_stall is high whenever a request is in progress,
// and a finished response waits in the sequencer while rsp_stall holds the
// response register full.
module interrupt_controller_dual_timer #(
   parameter int TIMER_COUNT = icdt_pkg::TIMER_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  icdt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output icdt_pkg::rsp_type rsp_payload
);
   import icdt_pkg::*;

   localparam int IDX_W = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

   seq_state_type state_ff, state_in;
   logic [7:0]    pending_ff, pending_in;
   logic [7:0]    enable_ff, enable_in;
   logic          fast_enable_ff, fast_enable_in;
   logic          ext_irq_ff, ext_irq_in;
   logic          ext_fiq_ff, ext_fiq_in;
   logic [7:0]    rd_ff, rd_in;
   logic          fiq_ff, fiq_in;
   logic [CYCLES_W-1:0] cycles_ff, cycles_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_payload_ff, rsp_payload_in;

   tmr_ctl_type         tmr_ctl;
   tmr_sts_type         tmr_sts;
   logic [PERIOD_W-1:0] rate_period;

   function automatic logic [7:0] raise_bit(input logic [7:0] pending,
                                            input logic [7:0] enable,
                                            input logic [2:0] bit_sel);
      logic [7:0] mask;
      mask = 8'd1 << bit_sel;
      if ((enable & mask) == 8'd0) begin
         return pending & ~mask;
      end
      return pending;
   endfunction

   assign rate_period = (req_payload.write_data == 8'd0) ? '0 :
                        PERIOD_W'(RATE_STEP * PERIOD_W'({1'b0, req_payload.write_data} + 9'd1));

   icdt_timers #(
      .TIMER_COUNT(TIMER_COUNT)
   ) u_timers (
      .clock   (clock),
      .reset   (reset),
      .tmr_ctl (tmr_ctl),
      .tmr_sts (tmr_sts)
   );

   always_comb begin
      state_in       = state_ff;
      pending_in     = pending_ff;
      enable_in      = enable_ff;
      fast_enable_in = fast_enable_ff;
      ext_irq_in     = ext_irq_ff;
      ext_fiq_in     = ext_fiq_ff;
      rd_in          = rd_ff;
      fiq_in         = fiq_ff;
      cycles_in      = cycles_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      tmr_ctl.op     = TMR_NOP;
      tmr_ctl.index  = TIMER_IDX_W'(idx_ff);
      tmr_ctl.cycles = cycles_ff;
      tmr_ctl.period = rate_period;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               rd_in    = 8'd0;
               fiq_in   = 1'b0;
               state_in = SEQ_DONE;
               unique case (req_payload.mode)
                  MODE_TICK: begin
                     cycles_in = req_payload.cycles;
                     idx_in    = '0;
                     state_in  = SEQ_ADD;
                  end
                  MODE_TIMER_WR: begin
                     if (int'(req_payload.timer_select) < TIMER_COUNT) begin
                        tmr_ctl.op    = TMR_LOAD;
                        tmr_ctl.index = TIMER_IDX_W'(req_payload.timer_select);
                     end
                  end
                  MODE_IRQ_EN_WR: begin
                     enable_in = req_payload.write_data;
                  end
                  MODE_FIQ_EN_WR: begin
                     fiq_in = !fast_enable_ff && req_payload.write_data[0] && ext_fiq_ff;
                     fast_enable_in = req_payload.write_data[0];
                  end
                  MODE_PEND_RD: begin
                     rd_in      = pending_ff;
                     pending_in = PENDING_NONE;
                  end
                  MODE_EXT_IRQ: begin
                     if (req_payload.level && !ext_irq_ff) begin
                        pending_in = raise_bit(pending_ff, enable_ff, EXT_IRQ_BIT);
                     end
                     ext_irq_in = req_payload.level;
                  end
                  MODE_EXT_FIQ: begin
                     fiq_in     = req_payload.level && !ext_fiq_ff && fast_enable_ff;
                     ext_fiq_in = req_payload.level;
                  end
                  MODE_RAISE: begin
                     pending_in = raise_bit(pending_ff, enable_ff, req_payload.irq_bit);
                  end
                  default: begin
                  end
               endcase
            end
         end
         SEQ_ADD: begin
            if (tmr_sts.zero) begin
               // stopped timer, move on
               if (idx_ff == LAST_IDX) begin
                  state_in = SEQ_DONE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               tmr_ctl.op = TMR_ADD;
               state_in   = SEQ_SUB;
            end
         end
         SEQ_SUB: begin
            // one period off per cycle until the count drops below it
            tmr_ctl.op = TMR_SUB;
            if (tmr_sts.ge) begin
               pending_in = raise_bit(pending_ff, enable_ff, 3'(idx_ff));
            end else if (idx_ff == LAST_IDX) begin
               state_in = SEQ_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = SEQ_ADD;
            end
         end
         SEQ_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_payload_in.read_data = rd_ff;
               rsp_payload_in.irq_line  = |(~pending_ff & ~enable_ff);
               rsp_payload_in.fiq_pulse = fiq_ff;
               state_in                 = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SEQ_IDLE;
         pending_ff     <= PENDING_NONE;
         enable_ff      <= ENABLE_NONE;
         fast_enable_ff <= 1'b1;
         ext_irq_ff     <= 1'b0;
         ext_fiq_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         pending_ff     <= pending_in;
         enable_ff      <= enable_in;
         fast_enable_ff <= fast_enable_in;
         ext_irq_ff     <= ext_irq_in;
         ext_fiq_ff     <= ext_fiq_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff          <= rd_in;
      fiq_ff         <= fiq_in;
      cycles_ff      <= cycles_in;
      idx_ff         <= idx_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_stall   = (state_ff != SEQ_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
